@@ hw/rtl/bsd_pkg.sv @@
package bsd_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W    = 17;
   localparam int LEN_W      = 16;
   localparam int MLEN_W     = 3;

   typedef enum logic [2:0] {
      CAUSE_MID    = 3'd0,
      CAUSE_LENGTH = 3'd1,
      CAUSE_MARK   = 3'd2,
      CAUSE_EMPTY  = 3'd3,
      CAUSE_FLUSH  = 3'd4,
      CAUSE_BYPASS = 3'd5
   } cause_type;

   typedef enum logic [2:0] {
      REG_ENABLE       = 3'd0,
      REG_FIXED_MODE   = 3'd1,
      REG_FRAME_LENGTH = 3'd2,
      REG_MARK_LENGTH  = 3'd3,
      REG_MARK_BYTES   = 3'd4,
      REG_BUFFER_LIMIT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic              enable;
      logic              fixed_mode;
      logic [LEN_W-1:0]  frame_length;
      logic [MLEN_W-1:0] mark_length;
      logic [31:0]       mark_bytes;
      logic [LEN_W-1:0]  buffer_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      cause_type  end_cause;
   } rsp_type;

endpackage

@@ hw/rtl/bsd_csr.sv @@
module bsd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bsd_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bsd_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bsd_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output bsd_pkg::cfg_type                   cfg
);
   import bsd_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            REG_ENABLE:       cfg_in.enable       = csr_pwdata[0];
            REG_FIXED_MODE:   cfg_in.fixed_mode   = csr_pwdata[0];
            REG_FRAME_LENGTH: cfg_in.frame_length = csr_pwdata[LEN_W-1:0];
            REG_MARK_LENGTH:  cfg_in.mark_length  = csr_pwdata[MLEN_W-1:0];
            REG_MARK_BYTES:   cfg_in.mark_bytes   = csr_pwdata[31:0];
            REG_BUFFER_LIMIT: cfg_in.buffer_limit = csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_ENABLE:       csr_prdata = CSR_DATA_W'(cfg_ff.enable);
         REG_FIXED_MODE:   csr_prdata = CSR_DATA_W'(cfg_ff.fixed_mode);
         REG_FRAME_LENGTH: csr_prdata = CSR_DATA_W'(cfg_ff.frame_length);
         REG_MARK_LENGTH:  csr_prdata = CSR_DATA_W'(cfg_ff.mark_length);
         REG_MARK_BYTES:   csr_prdata = CSR_DATA_W'(cfg_ff.mark_bytes);
         REG_BUFFER_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.buffer_limit);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.fixed_mode   <= 1'b0;
         cfg_ff.frame_length <= LEN_W'(1);
         cfg_ff.mark_length  <= '0;
         cfg_ff.mark_bytes   <= '0;
         cfg_ff.buffer_limit <= LEN_W'(1024);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/bsd_frame.sv @@
module bsd_frame #(
   parameter int MARK_MAX = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  bsd_pkg::cfg_type cfg,
   input  logic             step,
   input  logic [7:0]       in_byte,
   output bsd_pkg::rsp_type rsp
);
   import bsd_pkg::*;

   localparam int MarkCap = (MARK_MAX < 4) ? MARK_MAX : 4;
   localparam int RecentW = 8 * MarkCap;

   logic [COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic [RecentW-1:0] recent_ff, recent_in;
   logic [COUNT_W-1:0] count;
   logic [LEN_W-1:0]   flen;
   logic [MLEN_W-1:0]  mlen;
   logic               mark_hit;
   cause_type          cause;

   assign count     = (&frame_count_ff) ? frame_count_ff : frame_count_ff + 1'b1;
   assign recent_in = RecentW'({recent_ff, in_byte});
   assign flen      = (cfg.frame_length == '0) ? LEN_W'(1) : cfg.frame_length;
   assign mlen      = (cfg.mark_length > MLEN_W'(MarkCap)) ? MLEN_W'(MarkCap)
                                                            : cfg.mark_length;

   always_comb begin
      mark_hit = (count >= COUNT_W'(mlen));
      for (int i = 0; i < MarkCap; i++) begin
         if (MLEN_W'(i) < mlen && recent_in[8*i +: 8] != cfg.mark_bytes[8*i +: 8]) begin
            mark_hit = 1'b0;
         end
      end
   end

   always_comb begin
      cause = CAUSE_MID;
      if (!cfg.enable) begin
         cause = CAUSE_BYPASS;
      end else begin
         if (cfg.fixed_mode) begin
            if (count >= COUNT_W'(flen)) cause = CAUSE_LENGTH;
         end else if (mlen == '0) begin
            cause = CAUSE_EMPTY;
         end else if (mark_hit) begin
            cause = CAUSE_MARK;
         end
         if (cause == CAUSE_MID && count > COUNT_W'(cfg.buffer_limit)) begin
            cause = CAUSE_FLUSH;
         end
      end
   end

   assign rsp.out_byte  = in_byte;
   assign rsp.frame_end = (cause != CAUSE_MID);
   assign rsp.end_cause = cause;

   assign frame_count_in = (cause == CAUSE_MID) ? count : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         recent_ff      <= '0;
      end else if (step && cfg.enable) begin
         frame_count_ff <= frame_count_in;
         recent_ff      <= recent_in;
      end
   end

endmodule

@@ hw/rtl/bsd_out.sv @@
module bsd_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bsd_pkg::rsp_type load_data,
   output logic             can_load,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsd_pkg::rsp_type rsp_data
);
   import bsd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

@@ hw/rtl/byte_stream_deframer.sv @@
// channel  ports                    tdata / tuser / tlast
// ------   -----------------------  ------------------------------------------
// req      req_tvalid, req_tready   tdata[7:0] data_byte
// rsp      rsp_tvalid, rsp_tready   tdata[7:0] out_byte, tuser[2:0] end_cause,
//                                   tlast frame_end
// csr      APB, 32-bit data         regs at 4*i: enable, fixed_mode,
//                                   frame_length, mark_length, mark_bytes,
//                                   buffer_limit
//
// One word per cycle sustained while rsp is not stalled; a taken word passes
// through an input register, then the count and mark compare into the
// output register. Synchronous reset clears control, frame count and history.
// A stalled rsp holds the output register; the input register keeps taking
// words while the output register is free or drains in the same cycle.
module byte_stream_deframer #(
   parameter int MARK_MAX = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] data_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // [7:0] out_byte
   output logic [2:0]                     rsp_tuser,   // [2:0] end_cause
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bsd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bsd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bsd_pkg::*;

   cfg_type    cfg;
   rsp_type    frame_rsp;
   rsp_type    out_rsp;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       advance;
   logic       out_can_load;
   logic       req_take;

   bsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance     = in_valid_ff && out_can_load;
   assign req_tready  = !in_valid_ff || out_can_load;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !out_can_load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
   end

   bsd_frame #(
      .MARK_MAX (MARK_MAX)
   ) u_frame (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .in_byte (in_byte_ff),
      .rsp     (frame_rsp)
   );

   bsd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (frame_rsp),
      .can_load  (out_can_load),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (out_rsp)
   );

   assign rsp_tdata = out_rsp.out_byte;
   assign rsp_tuser = out_rsp.end_cause;
   assign rsp_tlast = out_rsp.frame_end;

   a_last_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != CAUSE_MID)))
      else $error("tlast disagrees with end cause");

   a_stalled_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_can_load |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input word lost");

   a_bypass_when_disabled: assert property (@(posedge clock) disable iff (reset)
      advance && !cfg.enable |=> rsp_tuser == CAUSE_BYPASS)
      else $error("disabled word not marked bypass");

endmodule

@@ verif/tb_byte_stream_deframer.sv @@
module tb_byte_stream_deframer;
   import bsd_pkg::*;

   localparam int MARK_CAP       = 4;
   localparam int MAX_SHOWN      = 10;
   localparam int SETTLE_CYCLES  = 6;
   localparam int DRAIN_LIMIT    = 20000;
   localparam int ROUND_WORDS    = 35;
   localparam int HOLD_OFF       = 250;
   localparam int LONG_RUN_WORDS = 22;
   localparam int TIMEOUT_CYCLES = 3000000;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_tvalid   = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata    = '0;   // [7:0] data_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready   = 1'b0;
   logic [7:0]            rsp_tdata;           // [7:0] out_byte
   logic [2:0]            rsp_tuser;           // [2:0] end_cause
   logic                  rsp_tlast;
   logic                  csr_psel     = 1'b0;
   logic                  csr_penable  = 1'b0;
   logic                  csr_pwrite   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr    = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata   = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type     shadow_cfg;
   logic [16:0] frame_bytes;
   logic [31:0] byte_history;
   rsp_type     expected_words[$];
   rsp_type     head_word;
   int          mismatches         = 0;
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   int          hold_off_cycles    = 0;

   byte_stream_deframer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected word: byte %h last %b cause %0d",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            head_word = expected_words.pop_front();
            if (rsp_tdata !== head_word.out_byte || rsp_tlast !== head_word.frame_end ||
                rsp_tuser !== head_word.end_cause) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display({"word mismatch: expected byte %h last %b cause %s, ",
                            "got byte %h last %b cause %0d"},
                           head_word.out_byte, head_word.frame_end,
                           head_word.end_cause.name(), rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   function automatic rsp_type deframe_predict(input logic [7:0] data);
      rsp_type     word;
      cause_type   cause;
      logic [16:0] next_count;
      logic [16:0] span;
      logic [31:0] mask;
      int          mark_used;
      word.out_byte = data;
      if (!shadow_cfg.enable) begin
         word.frame_end = 1'b1;
         word.end_cause = CAUSE_BYPASS;
         return word;
      end
      next_count = (frame_bytes == 17'h1FFFF) ? frame_bytes : frame_bytes + 17'd1;
      byte_history = {byte_history[23:0], data};
      cause = CAUSE_MID;
      if (shadow_cfg.fixed_mode) begin
         span = (shadow_cfg.frame_length == '0) ? 17'd1 : {1'b0, shadow_cfg.frame_length};
         if (next_count >= span)
            cause = CAUSE_LENGTH;
      end else begin
         mark_used = (shadow_cfg.mark_length > MARK_CAP) ? MARK_CAP : shadow_cfg.mark_length;
         if (mark_used == 0) begin
            cause = CAUSE_EMPTY;
         end else if (next_count >= mark_used) begin
            mask = (mark_used >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * mark_used)) - 32'd1);
            if ((byte_history & mask) == (shadow_cfg.mark_bytes & mask))
               cause = CAUSE_MARK;
         end
      end
      if (cause == CAUSE_MID && next_count > {1'b0, shadow_cfg.buffer_limit})
         cause = CAUSE_FLUSH;
      frame_bytes = (cause == CAUSE_MID) ? next_count : 17'd0;
      word.frame_end = (cause != CAUSE_MID);
      word.end_cause = cause;
      return word;
   endfunction

   task automatic send_word(input logic [7:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_words.push_back(deframe_predict(data));
   endtask

   task automatic drain_words();
      int waited = 0;
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type index, input logic [31:0] value);
      drain_words();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_ENABLE:       shadow_cfg.enable       = value[0];
         REG_FIXED_MODE:   shadow_cfg.fixed_mode   = value[0];
         REG_FRAME_LENGTH: shadow_cfg.frame_length = value[15:0];
         REG_MARK_LENGTH:  shadow_cfg.mark_length  = value[2:0];
         REG_MARK_BYTES:   shadow_cfg.mark_bytes   = value;
         REG_BUFFER_LIMIT: shadow_cfg.buffer_limit = value[15:0];
         default: ;
      endcase
   endtask

   task automatic test_bypass();
      send_word(8'h00);
      send_word(8'hFF);
   endtask

   task automatic test_fixed_frames();
      csr_write(REG_ENABLE, 32'd1);
      csr_write(REG_FIXED_MODE, 32'd1);
      csr_write(REG_FRAME_LENGTH, 32'd3);
      send_word(8'h01);
      send_word(8'h02);
      send_word(8'h03);
      // zero length acts as one
      csr_write(REG_FRAME_LENGTH, 32'd0);
      send_word(8'h04);
      // lower the length mid frame
      csr_write(REG_FRAME_LENGTH, 32'd10);
      send_word(8'h05);
      send_word(8'h06);
      send_word(8'h07);
      csr_write(REG_FRAME_LENGTH, 32'd2);
      send_word(8'h08);
      // length end beats flush on the same word
      csr_write(REG_BUFFER_LIMIT, 32'd1);
      send_word(8'h09);
      send_word(8'h0A);
      csr_write(REG_FRAME_LENGTH, 32'd6);
      send_word(8'h0B);
      send_word(8'h0C);
   endtask

   task automatic test_mark_frames();
      csr_write(REG_FIXED_MODE, 32'd0);
      csr_write(REG_BUFFER_LIMIT, 32'd1024);
      csr_write(REG_MARK_LENGTH, 32'd0);
      send_word(8'h33);
      // mark must lie inside the current frame
      csr_write(REG_MARK_LENGTH, 32'd2);
      csr_write(REG_MARK_BYTES, 32'h0000_4242);
      send_word(8'h42);
      send_word(8'h42);
      send_word(8'h42);
      // mark end beats flush on the same word
      csr_write(REG_BUFFER_LIMIT, 32'd1);
      send_word(8'h42);
      // oversized mark length saturates
      csr_write(REG_BUFFER_LIMIT, 32'd1024);
      csr_write(REG_MARK_LENGTH, 32'd7);
      csr_write(REG_MARK_BYTES, 32'hDEAD_BEEF);
      send_word(8'hDE);
      send_word(8'hAD);
      send_word(8'hBE);
      send_word(8'hEF);
      // bypass mid frame holds the history
      send_word(8'hDE);
      send_word(8'hAD);
      csr_write(REG_ENABLE, 32'd0);
      send_word(8'hBE);
      csr_write(REG_ENABLE, 32'd1);
      send_word(8'hBE);
      send_word(8'hEF);
   endtask

   task automatic test_long_frame();
      csr_write(REG_MARK_LENGTH, 32'd4);
      csr_write(REG_MARK_BYTES, 32'hFFFF_FFFF);
      // flush a frame that outgrows the buffer
      csr_write(REG_BUFFER_LIMIT, 32'd20);
      repeat (LONG_RUN_WORDS) send_word(8'h00);
      csr_write(REG_FIXED_MODE, 32'd1);
      csr_write(REG_FRAME_LENGTH, 32'd65535);
      repeat (4) send_word(8'($urandom));
   endtask

   task automatic test_backpressure();
      csr_write(REG_FIXED_MODE, 32'd1);
      csr_write(REG_FRAME_LENGTH, 32'd5);
      csr_write(REG_BUFFER_LIMIT, 32'd1024);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_cycles    = HOLD_OFF;
      repeat (40) send_word(8'($urandom));
      // hold the sender until everything is out
      drain_words();
      repeat (10) send_word(8'($urandom));
   endtask

   task automatic test_random_stream();
      int idle_pct[4]  = '{0, 60, 0, 27};
      int stall_pct[4] = '{0, 0, 60, 27};
      int sent;
      int mark_used;
      int pick;
      for (int phase = 0; phase < 4; phase++) begin
         for (int round = 0; round < 3; round++) begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
            csr_write(REG_ENABLE, 32'($urandom_range(9) != 0));
            csr_write(REG_FIXED_MODE, $urandom_range(1));
            pick = $urandom_range(9);
            csr_write(REG_FRAME_LENGTH, (pick == 0) ? 32'd0 :
                                        (pick == 1) ? 32'd65535 : $urandom_range(1, 16));
            csr_write(REG_MARK_LENGTH, ($urandom_range(9) == 0) ? $urandom_range(5, 7)
                                                                 : $urandom_range(0, 4));
            csr_write(REG_MARK_BYTES, $urandom);
            pick = $urandom_range(9);
            csr_write(REG_BUFFER_LIMIT, (pick == 0) ? 32'd0 :
                                        (pick == 1) ? 32'd65535 :
                                        (pick < 6)  ? $urandom_range(1, 24) : 32'd1024);
            sender_idle_pct    = idle_pct[phase];
            receiver_stall_pct = stall_pct[phase];
            mark_used = (shadow_cfg.mark_length > MARK_CAP) ? MARK_CAP : shadow_cfg.mark_length;
            sent = 0;
            while (sent < ROUND_WORDS) begin
               if (!shadow_cfg.fixed_mode && mark_used != 0 && $urandom_range(4) != 0) begin
                  repeat ($urandom_range(0, 8)) begin
                     send_word(8'($urandom));
                     sent++;
                  end
                  for (int k = mark_used - 1; k >= 0; k--) begin
                     send_word(shadow_cfg.mark_bytes[8*k +: 8]);
                     sent++;
                  end
               end else begin
                  send_word(8'($urandom));
                  sent++;
               end
            end
         end
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   initial begin
      shadow_cfg              = '0;
      shadow_cfg.frame_length = 16'd1;
      shadow_cfg.buffer_limit = 16'd1024;
      frame_bytes             = '0;
      byte_history            = '0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_bypass();
      test_fixed_frames();
      test_mark_frames();
      test_long_frame();
      test_backpressure();
      test_random_stream();
      drain_words();
      if (expected_words.size() != 0)
         $display("%0d words never arrived", expected_words.size());
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("timeout");
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
